/* rtl/obrb_pkg.sv */
// Package for the overwriting byte ring buffer: widths, command codes, shared types.
package obrb_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CAP_W   = PTR_W + 1;
  localparam int unsigned ALU_W   = CAP_W + 1;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CNT_W   = 8;

  localparam logic [CMD_W-1:0] CMD_PUT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd3;

  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

  // Operands of the shared compare-subtract unit
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             ge;
    logic [ALU_W-1:0] diff;
    logic [ALU_W-1:0] reduced;
  } alu_rsp_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic [CNT_W-1:0]  position;
    logic              found;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
  } result_t;

  // Bytes between read and write pointer in a ring of cap slots
  function automatic logic [CNT_W-1:0] ring_used(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] span;
    if (wp >= rp) begin
      span = {1'b0, wp - rp};
    end else begin
      span = cap - {1'b0, rp - wp};
    end
    return span[CNT_W-1:0];
  endfunction

endpackage

/* rtl/obrb_if.sv */
// Valid/ready channel interfaces for commands and results.
interface obrb_cmd_if import obrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;
  logic [CNT_W-1:0]  amount;

  modport source (output valid, command, data_byte, amount, input ready);
  modport sink   (input valid, command, data_byte, amount, output ready);
endinterface

interface obrb_res_if import obrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic [CNT_W-1:0]  position;
  logic              found;
  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, read_data, position, found, used_count, free_count,
                  input ready);
  modport sink   (input valid, read_data, position, found, used_count, free_count,
                  output ready);
endinterface

/* rtl/obrb_alu.sv */
// Shared compare-subtract unit: a >= b, a - b, and a reduced once by b.
module obrb_alu import obrb_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  always_comb begin
    rsp_o.ge      = (req_i.a >= req_i.b);
    rsp_o.diff    = req_i.a - req_i.b;
    rsp_o.reduced = rsp_o.ge ? rsp_o.diff : req_i.a;
  end

endmodule

/* rtl/obrb_store.sv */
// Byte store: one write port, one registered read port, per-entry valid bits.
module obrb_store import obrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_wr_t         wr_i,
  input  logic [PTR_W-1:0]  raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [BYTE_W-1:0] rdata_q;

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.we) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/overwriting_byte_ring_buffer_unit.sv */
// Top level of the overwriting byte ring buffer: sequencer, pointers, result register.
//
//  channel | dir | handshake       | payload
//  cmd_i   | in  | valid / ready   | command, data_byte, amount
//  res_o   | out | valid / ready   | read_data, position, found, used_count, free_count
//  cfg     | in  | cfg_we_i        | cfg_wdata_i = capacity (clamped to 2..256)
//
// Steps per transaction, from accept to result in the output register:
// put a write step, plus a read-pointer step when the oldest byte is dropped;
// advance and peek 8 restoring-division steps for amount mod capacity, one
// ring add, peek also one store read; search setup plus one per stored byte examined.
// Division steps and ring wraps share the compare-subtract unit; cmd_i.ready is low
// until the sequencer returns to idle. Reset clears pointers and store valid
// bits at once (no sweep). The result step waits while the output register
// still holds an untaken result; cmd_i.ready stays low for that time too.
module overwriting_byte_ring_buffer_unit import obrb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  obrb_cmd_if.sink         cmd_i,
  obrb_res_if.source       res_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_ADD    = 4'd2;
  localparam logic [3:0] S_PEEK   = 4'd3;
  localparam logic [3:0] S_PUT    = 4'd4;
  localparam logic [3:0] S_PUT2   = 4'd5;
  localparam logic [3:0] S_SINIT  = 4'd6;
  localparam logic [3:0] S_SRCH   = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CAP_W-1:0]  cap_q, cap_d;

  // per-transaction working registers
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]  amt_q, amt_d;
  logic [CAP_W-1:0]  rem_q, rem_d;
  logic [2:0]        bit_q, bit_d;
  logic [PTR_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  k_q, k_d, n_q, n_d;
  logic [BYTE_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic              fnd_q, fnd_d;

  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  store_wr_t         st_wr;
  logic [PTR_W-1:0]  st_raddr;
  logic [BYTE_W-1:0] st_rdata;
  logic [CNT_W-1:0]  used_now;
  logic              cmd_fire;

  obrb_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  obrb_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (st_wr),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign used_now    = ring_used(wp_q, rp_q, cap_q);

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    cap_d       = cap_q;
    cmd_d       = cmd_q;
    data_d      = data_q;
    amt_d       = amt_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    k_d         = k_q;
    n_d         = n_q;
    rd_d        = rd_q;
    pos_d       = pos_q;
    fnd_d       = fnd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    alu_req.a   = '0;
    alu_req.b   = {1'b0, cap_q};
    st_wr       = '0;
    st_raddr    = rp_q;

    if (res_o.valid && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          cmd_d  = cmd_i.command;
          data_d = cmd_i.data_byte;
          amt_d  = cmd_i.amount;
          rem_d  = '0;
          bit_d  = 3'd7;
          rd_d   = '0;
          pos_d  = '0;
          fnd_d  = 1'b0;
          unique case (cmd_i.command)
            CMD_PUT:     state_d = S_PUT;
            CMD_PEEK:    state_d = S_DIV;
            CMD_ADVANCE: state_d = S_DIV;
            CMD_SEARCH:  state_d = S_SINIT;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      // one restoring-division step per cycle: rem = amount mod capacity
      S_DIV: begin
        alu_req.a = {rem_q, amt_q[bit_q]};
        rem_d     = alu_rsp.reduced[CAP_W-1:0];
        bit_d     = bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          state_d = S_ADD;
        end
      end
      // rp + rem < 2 * capacity, so one conditional subtract wraps it
      S_ADD: begin
        alu_req.a = {2'b00, rp_q} + {1'b0, rem_q};
        st_raddr  = alu_rsp.reduced[PTR_W-1:0];
        if (cmd_q == CMD_PEEK) begin
          state_d = S_PEEK;
        end else begin
          rp_d    = alu_rsp.reduced[PTR_W-1:0];
          pos_d   = alu_rsp.reduced[CNT_W-1:0];
          state_d = S_RESULT;
        end
      end
      S_PEEK: begin
        rd_d    = st_rdata;
        state_d = S_RESULT;
      end
      S_PUT: begin
        st_wr.we   = 1'b1;
        st_wr.addr = wp_q;
        st_wr.data = data_q;
        alu_req.a  = {2'b00, wp_q} + ALU_W'(1);
        wp_d       = alu_rsp.reduced[PTR_W-1:0];
        pos_d      = alu_rsp.reduced[CNT_W-1:0];
        // ring full: drop the oldest byte
        if (alu_rsp.reduced[PTR_W-1:0] == rp_q) begin
          state_d = S_PUT2;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_PUT2: begin
        alu_req.a = {2'b00, rp_q} + ALU_W'(1);
        rp_d      = alu_rsp.reduced[PTR_W-1:0];
        state_d   = S_RESULT;
      end
      S_SINIT: begin
        n_d      = used_now;
        k_d      = '0;
        idx_d    = rp_q;
        st_raddr = rp_q;
        if (used_now == '0) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_SRCH;
        end
      end
      // read data is for idx_q; next index is fetched in the same cycle
      S_SRCH: begin
        alu_req.a = {2'b00, idx_q} + ALU_W'(1);
        idx_d     = alu_rsp.reduced[PTR_W-1:0];
        st_raddr  = alu_rsp.reduced[PTR_W-1:0];
        if (st_rdata == data_q) begin
          fnd_d   = 1'b1;
          pos_d   = k_q;
          state_d = S_RESULT;
        end else if (({1'b0, k_q} + 9'd1) == {1'b0, n_q}) begin
          state_d = S_RESULT;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      S_RESULT: begin
        if (!out_valid_q || res_o.ready) begin
          out_d.read_data  = rd_q;
          out_d.position   = pos_q;
          out_d.found      = fnd_q;
          out_d.used_count = used_now;
          out_d.free_count = CNT_W'(cap_q - CAP_W'(1) - {1'b0, used_now});
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // capacity write empties the ring; stored bytes stay
    if (cfg_we_i) begin
      if (cfg_wdata_i < CAP_MIN) begin
        cap_d = CAP_MIN;
      end else if (cfg_wdata_i > CAP_MAX) begin
        cap_d = CAP_MAX;
      end else begin
        cap_d = cfg_wdata_i;
      end
      wp_d = '0;
      rp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      cap_q       <= CAP_MAX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    data_q <= data_d;
    amt_q  <= amt_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    idx_q  <= idx_d;
    k_q    <= k_d;
    n_q    <= n_d;
    rd_q   <= rd_d;
    pos_q  <= pos_d;
    fnd_q  <= fnd_d;
    out_q  <= out_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.read_data  = out_q.read_data;
  assign res_o.position   = out_q.position;
  assign res_o.found      = out_q.found;
  assign res_o.used_count = out_q.used_count;
  assign res_o.free_count = out_q.free_count;

  // pointers always stay inside the ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wp_q} < cap_q) && ({1'b0, rp_q} < cap_q))
    else $error("ring pointer at or beyond capacity");

  // an accepted command leaves cmd_i.ready low in the cycle after
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire |=> !cmd_i.ready)
    else $error("command accepted back to back");

  // division leaves a reduced remainder
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> (rem_q < cap_q))
    else $error("remainder not below capacity");

  // search never walks past the stored bytes
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (k_q < n_q))
    else $error("search index beyond used count");

endmodule
